// ===== rtl/bdq_pkg.sv =====
// Shared operation and status codes for the bounded deque with search.
package bdq_pkg;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_RM_VALUE  = 3'd2,
    KIND_RM_FRONT  = 3'd3,
    KIND_RM_BACK   = 3'd4,
    KIND_CLEAR     = 3'd5,
    KIND_CONTAINS  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

// ===== rtl/bdq_if.sv =====
// Request and response channel interfaces for the bounded deque.
interface bdq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_WIDTH  = 5
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  found;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CNT_WIDTH-1:0]  entry_count;
  logic                  is_empty;

  modport source (output valid, output status, output found, output front_value,
                  output back_value, output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input front_value,
                  input back_value, input entry_count, input is_empty, output ready);
endinterface

// ===== rtl/bdq_ram.sv =====
// Entry store: one write port and one registered read port.
module bdq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_WIDTH-1:0]                    wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_WIDTH-1:0]                    rdata_o
);
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/bdq_addr.sv =====
// Shared index unit: maps a position from the front to a slot of the ring.
module bdq_addr #(
  parameter int DEPTH = 16
) (
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] head_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] lidx_i,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] phys_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  assign sum     = {1'b0, head_i} + {1'b0, lidx_i};
  assign wrapped = sum - DEPTH_W;
  assign phys_o  = (sum >= DEPTH_W) ? wrapped[AW-1:0] : sum[AW-1:0];
endmodule

// ===== rtl/bounded_deque_with_search_unit.sv =====
// Bounded deque with search: top level with the operation sequencer.
// Values are kept in a ring in a memory with one registered read port; a head pointer and a
// count locate the front and back. Front and back inserts and removals, clear and the unused
// kind go to the finish: read the front entry, then the back entry, then load the output
// register; both reads are skipped when the store ends empty. Contains and remove-by-value
// scan from the front, reading and then comparing each entry examined (no scan on an empty
// store); on a match, removal by value moves each later entry one place forward, reading and
// then writing it, before the same finish. A request is taken only while the sequencer is
// idle, so the next one is accepted in the same cycle as a result appears at the earliest; a
// finished result waits in an output register, so the next request may be taken meanwhile,
// and the sequencer holds at its last step while that register is still occupied.
module bounded_deque_with_search_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdq_req_if.sink     req_i,
  bdq_rsp_if.source   rsp_o
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SRCH_RD = 3'd1;
  localparam logic [2:0] S_SRCH_CM = 3'd2;
  localparam logic [2:0] S_SH_RD   = 3'd3;
  localparam logic [2:0] S_SH_WR   = 3'd4;
  localparam logic [2:0] S_FR_RD   = 3'd5;
  localparam logic [2:0] S_BK_RD   = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  rm_q, rm_d;
  status_e               st_q, st_d;
  logic                  found_q, found_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;

  logic                  rsp_valid_q;
  logic [1:0]            rsp_status_q;
  logic                  rsp_found_q;
  logic [DATA_WIDTH-1:0] rsp_front_q;
  logic [DATA_WIDTH-1:0] rsp_back_q;
  logic [CW-1:0]         rsp_count_q;
  logic                  rsp_empty_q;

  logic                  accept;
  logic                  load_out;
  logic [AW-1:0]         lidx;
  logic [AW-1:0]         phys;
  logic [AW-1:0]         head_dec;
  logic [CW-1:0]         idx_nx;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [DATA_WIDTH-1:0] rdata;

  bdq_addr #(.DEPTH(DEPTH)) u_addr (
    .head_i (head_q),
    .lidx_i (lidx),
    .phys_o (phys)
  );

  bdq_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (phys),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign head_dec    = (head_q == '0) ? LAST_C : head_q - AW'(1);
  assign idx_nx      = idx_q + CW'(1);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    val_d    = val_q;
    rm_d     = rm_q;
    st_d     = st_q;
    found_d  = found_q;
    front_d  = front_q;
    load_out = 1'b0;
    lidx     = '0;
    we       = 1'b0;
    waddr    = phys;
    wdata    = val_q;
    re       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        lidx = (req_i.kind == KIND_INS_BACK) ? cnt_q[AW-1:0] : AW'(1);
        if (accept) begin
          val_d   = req_i.value;
          rm_d    = (req_i.kind == KIND_RM_VALUE);
          st_d    = ST_DONE;
          found_d = 1'b0;
          idx_d   = '0;
          state_d = S_FR_RD;
          unique case (kind_e'(req_i.kind))
            KIND_INS_FRONT: begin
              if (cnt_q == DEPTH_C) begin
                st_d = ST_FULL;
              end else begin
                head_d = head_dec;
                we     = 1'b1;
                waddr  = head_dec;
                wdata  = req_i.value;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            KIND_INS_BACK: begin
              if (cnt_q == DEPTH_C) begin
                st_d = ST_FULL;
              end else begin
                we    = 1'b1;
                wdata = req_i.value;
                cnt_d = cnt_q + CW'(1);
              end
            end
            KIND_RM_VALUE, KIND_CONTAINS: begin
              if (cnt_q == '0) begin
                if (req_i.kind == KIND_RM_VALUE) begin
                  st_d = ST_EMPTY;
                end
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            KIND_RM_FRONT: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                head_d = phys;
                cnt_d  = cnt_q - CW'(1);
              end
            end
            KIND_RM_BACK: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            KIND_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        lidx    = idx_q[AW-1:0];
        re      = 1'b1;
        state_d = S_SRCH_CM;
      end
      S_SRCH_CM: begin
        if (rdata == val_q) begin
          if (rm_q) begin
            state_d = S_SH_RD;
          end else begin
            found_d = 1'b1;
            state_d = S_FR_RD;
          end
        end else if (idx_nx == cnt_q) begin
          if (rm_q) begin
            st_d = ST_NOT_FOUND;
          end
          state_d = S_FR_RD;
        end else begin
          idx_d   = idx_nx;
          state_d = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        lidx = idx_nx[AW-1:0];
        if (idx_nx < cnt_q) begin
          re      = 1'b1;
          state_d = S_SH_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FR_RD;
        end
      end
      S_SH_WR: begin
        lidx    = idx_q[AW-1:0];
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_nx;
        state_d = S_SH_RD;
      end
      S_FR_RD: begin
        lidx = '0;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          re      = 1'b1;
          state_d = S_BK_RD;
        end
      end
      S_BK_RD: begin
        lidx    = AW'(cnt_q - CW'(1));
        re      = 1'b1;
        front_d = rdata;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    rm_q    <= rm_d;
    st_q    <= st_d;
    found_q <= found_d;
    front_q <= front_d;
    if (load_out) begin
      rsp_status_q <= st_q;
      rsp_found_q  <= found_q;
      rsp_front_q  <= (cnt_q == '0) ? '0 : front_q;
      rsp_back_q   <= (cnt_q == '0) ? '0 : rdata;
      rsp_count_q  <= cnt_q;
      rsp_empty_q  <= (cnt_q == '0);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.front_value = rsp_front_q;
  assign rsp_o.back_value  = rsp_back_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.is_empty    = rsp_empty_q;
endmodule

// ===== rtl/bdq_checker.sv =====
// Port-level checks on the bounded deque response channel, bound to the top level.
module bdq_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [1:0]                    rsp_status_i,
  input logic                          rsp_found_i,
  input logic [DATA_WIDTH-1:0]         rsp_front_i,
  input logic [DATA_WIDTH-1:0]         rsp_back_i,
  input logic [$clog2(DEPTH+1)-1:0]    rsp_count_i,
  input logic                          rsp_empty_i
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_found_i) && $stable(rsp_front_i) && $stable(rsp_back_i) &&
      $stable(rsp_count_i))
    else $error("response changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= DEPTH_C && rsp_empty_i == (rsp_count_i == '0) &&
      (!rsp_empty_i || (rsp_front_i == '0 && rsp_back_i == '0)))
    else $error("count, empty flag and end values disagree");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_count_i == DEPTH_C)
    else $error("insert dropped while store not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_EMPTY |-> rsp_empty_i && !rsp_found_i)
    else $error("empty status with entries stored");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_found_i |-> rsp_status_i == ST_DONE && !rsp_empty_i)
    else $error("value found in inconsistent result");
endmodule

bind bounded_deque_with_search_unit bdq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_found_i  (rsp_o.found),
  .rsp_front_i  (rsp_o.front_value),
  .rsp_back_i   (rsp_o.back_value),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_empty_i  (rsp_o.is_empty)
);

// ===== verif/tb_bounded_deque_with_search_unit.sv =====
// Self-checking testbench for the bounded deque with search, with a shadow deque scoreboard.
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_unit;
  import bdq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int CNT_WIDTH    = 5;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SEGMENT_LEN  = 40;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam logic [31:0] VALUE_POOL [6] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5
  };

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [31:0]          front_value;
    logic [31:0]          back_value;
    logic [CNT_WIDTH-1:0] entry_count;
    logic                 is_empty;
  } deque_rsp_t;

  class deque_scoreboard;
    logic [31:0] contents[$];
    deque_rsp_t  expected_rsp[$];
    int          errors;
    int          checked;
    int          kind_seen[8];
    int          status_seen[4];
    int          peak_fill;

    function int first_index(logic [31:0] value);
      for (int i = 0; i < contents.size(); i++) begin
        if (contents[i] == value) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [2:0] kind, logic [31:0] value);
      deque_rsp_t r;
      int         idx;
      r = '0;
      r.status = ST_DONE;
      case (kind)
        KIND_INS_FRONT: begin
          if (contents.size() >= DEPTH) r.status = ST_FULL;
          else contents.push_front(value);
        end
        KIND_INS_BACK: begin
          if (contents.size() >= DEPTH) r.status = ST_FULL;
          else contents.push_back(value);
        end
        KIND_RM_VALUE: begin
          if (contents.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            idx = first_index(value);
            if (idx < 0) r.status = ST_NOT_FOUND;
            else contents.delete(idx);
          end
        end
        KIND_RM_FRONT: begin
          if (contents.size() == 0) r.status = ST_EMPTY;
          else void'(contents.pop_front());
        end
        KIND_RM_BACK: begin
          if (contents.size() == 0) r.status = ST_EMPTY;
          else void'(contents.pop_back());
        end
        KIND_CLEAR: contents.delete();
        KIND_CONTAINS: r.found = (first_index(value) >= 0);
        default: ;
      endcase
      if (contents.size() > 0) begin
        r.front_value = contents[0];
        r.back_value  = contents[contents.size()-1];
      end
      r.entry_count = CNT_WIDTH'(contents.size());
      r.is_empty    = (contents.size() == 0);
      if (contents.size() > peak_fill) peak_fill = contents.size();
      kind_seen[kind]++;
      status_seen[r.status]++;
      expected_rsp.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_response(deque_rsp_t got);
      deque_rsp_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got %h", $time, got);
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   snd_idle_pct;
  int   rcv_idle_pct;

  deque_scoreboard tracker = new();

  bdq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req ();
  bdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_WIDTH(CNT_WIDTH)) rsp ();

  bounded_deque_with_search_unit #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_req(logic [2:0] kind, logic [31:0] value);
    while ($urandom_range(99) < snd_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.value <= value;
    do @(posedge clk_i); while (!req.ready);
    tracker.note_request(kind, value);
  endtask

  // Hold the request channel low until every outstanding transaction has returned
  task automatic wait_all_returned();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [2:0] pick_kind(int grow_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) return KIND_CLEAR;
    if (r < 4) return KIND_UNUSED;
    if (r < 4 + grow_pct) return $urandom_range(1) ? KIND_INS_FRONT : KIND_INS_BACK;
    case ($urandom_range(3))
      0:       return KIND_RM_VALUE;
      1:       return KIND_RM_FRONT;
      2:       return KIND_RM_BACK;
      default: return KIND_CONTAINS;
    endcase
  endfunction

  // Favour values already stored so that searches and removals hit
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45 && tracker.contents.size() > 0)
      return tracker.contents[$urandom_range(tracker.contents.size()-1)];
    if (r < 75) return VALUE_POOL[$urandom_range(5)];
    return $urandom();
  endfunction

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready)
        tracker.check_response(deque_rsp_t'{rsp.status, rsp.found, rsp.front_value,
                                            rsp.back_value, rsp.entry_count, rsp.is_empty});
      rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int grow_pct;
    int per_phase;
    rst_ni       <= 1'b0;
    req.valid    <= 1'b0;
    req.kind     <= KIND_INS_FRONT;
    req.value    <= '0;
    snd_idle_pct = 37;
    rcv_idle_pct = 70;
    grow_pct     = 50;
    per_phase    = RANDOM_ITEMS / 3;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(KIND_CONTAINS, VALUE_POOL[0]);
    send_req(KIND_RM_VALUE, VALUE_POOL[0]);
    send_req(KIND_RM_FRONT, VALUE_POOL[1]);
    send_req(KIND_RM_BACK, VALUE_POOL[1]);
    send_req(KIND_CLEAR, VALUE_POOL[1]);
    send_req(KIND_UNUSED, VALUE_POOL[1]);
    for (int i = 0; i < DEPTH; i++)
      send_req(i[0] ? KIND_INS_FRONT : KIND_INS_BACK,
               (i < 6) ? VALUE_POOL[i] : (i == 6) ? VALUE_POOL[0] : $urandom());
    send_req(KIND_INS_FRONT, VALUE_POOL[2]);
    send_req(KIND_INS_BACK, VALUE_POOL[3]);
    send_req(KIND_CONTAINS, VALUE_POOL[1]);
    send_req(KIND_RM_VALUE, VALUE_POOL[0]);
    send_req(KIND_RM_VALUE, 32'h1234_5678);
    send_req(KIND_UNUSED, VALUE_POOL[4]);
    send_req(KIND_CLEAR, VALUE_POOL[5]);
    wait_all_returned();

    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 37 : (p == 1) ? 70 : 0;
      rcv_idle_pct = (p == 0) ? 70 : (p == 1) ? 37 : 0;
      for (int n = 0; n < per_phase; n++) begin
        if (n % SEGMENT_LEN == 0) grow_pct = 25 * $urandom_range(3, 1);
        send_req(pick_kind(grow_pct), pick_value());
      end
      wait_all_returned();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.errors++;
      $display("%0t: %0d transactions never returned, expected 0", $time, tracker.pending());
    end

    $display({"Checked %0d transactions: front/back inserts %0d/%0d, value removals %0d, ",
              "front/back removals %0d/%0d, clears %0d, searches %0d, unused kind %0d"},
             tracker.checked, tracker.kind_seen[KIND_INS_FRONT],
             tracker.kind_seen[KIND_INS_BACK], tracker.kind_seen[KIND_RM_VALUE],
             tracker.kind_seen[KIND_RM_FRONT], tracker.kind_seen[KIND_RM_BACK],
             tracker.kind_seen[KIND_CLEAR], tracker.kind_seen[KIND_CONTAINS],
             tracker.kind_seen[KIND_UNUSED]);
    $display({"Peak fill %0d of %0d; %0d inserts dropped when full, ",
              "%0d removals on empty, %0d value misses"},
             tracker.peak_fill, DEPTH, tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_NOT_FOUND]);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ram.sv
rtl/bdq_addr.sv
rtl/bounded_deque_with_search_unit.sv
rtl/bdq_checker.sv
verif/tb_bounded_deque_with_search_unit.sv
